// ===== hdl/dsr_pkg.sv =====
// dsr_pkg: shared constants and controller/datapath interface types
// for the disc span rasterizer; no dependencies
package dsr_pkg;

   localparam int FRAME_WIDTH_DEF  = 128;
   localparam int FRAME_HEIGHT_DEF = 128;
   localparam int MAX_RADIUS_DEF   = 28;

   // payload widths fixed by the word format
   localparam int CENTER_W = 9;
   localparam int RADIUS_W = 5;
   localparam int PAINT_W  = 24;
   localparam int COORD_W  = 7;

   // internal signed coordinate width: holds centre +/- radius and frame
   // limits up to 4096
   localparam int POS_W = 14;
   // signed row offset, -31..31
   localparam int DY_W  = RADIUS_W + 2;
   // remaining squared extent r*r - dy*dy, 0..961
   localparam int SQ_W  = 2 * RADIUS_W;

   typedef struct packed {
      logic start;       // capture a new stamp
      logic adj_step;    // move half-width one step toward its row value
      logic advance;     // go to the next row
      logic load_pend;   // park current span as pending
      logic emit_pend;   // send pending span, not last
      logic emit_final;  // send last word: pending span or empty result
   } cmd_type;

   typedef struct packed {
      logic adj_need;    // half-width not yet at value for this row
      logic span_vis;    // current row gives a non-empty clipped span
      logic pend_valid;  // a span is waiting to be sent
      logic dy_at_end;   // current row is the bottom row of the disc
      logic out_free;    // output register can take a word this cycle
   } sts_type;

endpackage

// ===== hdl/dsr_ctrl.sv =====
// dsr_ctrl: sequencer that walks the disc rows for one stamp
// depends on dsr_pkg
module dsr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dsr_pkg::sts_type sts,
   output dsr_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WORK = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_WORK;
            end
         end
         ST_WORK: begin
            if (sts.adj_need) begin
               cmd.adj_step = 1'b1;
            end else if (!(sts.span_vis && sts.pend_valid && !sts.out_free)) begin
               // a new visible span pushes out the one parked before it
               cmd.emit_pend = sts.span_vis && sts.pend_valid;
               cmd.load_pend = sts.span_vis;
               if (sts.dy_at_end) begin
                  state_in = ST_FIN;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/dsr_datapath.sv =====
// dsr_datapath: row offset, half-width tracking, clipping, pending span
// and output register; depends on dsr_pkg
module dsr_datapath #(
   parameter int FRAME_WIDTH  = dsr_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = dsr_pkg::FRAME_HEIGHT_DEF,
   parameter int MAX_RADIUS   = dsr_pkg::MAX_RADIUS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [dsr_pkg::CENTER_W-1:0] req_center_x,
   input  logic signed [dsr_pkg::CENTER_W-1:0] req_center_y,
   input  logic        [dsr_pkg::RADIUS_W-1:0] req_radius,
   input  logic        [dsr_pkg::PAINT_W-1:0]  req_paint,
   input  dsr_pkg::cmd_type                    cmd,
   output dsr_pkg::sts_type                    sts,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [dsr_pkg::COORD_W-1:0]  rsp_row,
   output logic        [dsr_pkg::COORD_W-1:0]  rsp_x_start,
   output logic        [dsr_pkg::COORD_W-1:0]  rsp_x_end,
   output logic        [dsr_pkg::PAINT_W-1:0]  rsp_paint_out,
   output logic                                rsp_visible,
   output logic                                rsp_last
);

   localparam int RW = dsr_pkg::RADIUS_W;
   localparam int PW = dsr_pkg::POS_W;
   localparam int DW = dsr_pkg::DY_W;
   localparam int QW = dsr_pkg::SQ_W;
   localparam int CW = dsr_pkg::COORD_W;

   localparam logic signed [PW-1:0] XMAX = PW'(FRAME_WIDTH - 1);
   localparam logic signed [PW-1:0] YLIM = PW'(FRAME_HEIGHT);

   logic signed [PW-1:0] cx_ff, cy_ff;
   logic        [RW-1:0] r_ff, hw_ff;
   logic signed [DW-1:0] dy_ff;
   logic        [QW-1:0] q_ff;
   logic [dsr_pkg::PAINT_W-1:0] paint_ff;

   logic          pend_valid_ff;
   logic [CW-1:0] pend_row_ff, pend_xs_ff, pend_xe_ff;

   logic          out_valid_ff, out_vis_ff, out_last_ff;
   logic [CW-1:0] out_row_ff, out_xs_ff, out_xe_ff;
   logic [dsr_pkg::PAINT_W-1:0] out_paint_ff;

   logic [RW-1:0]        r_sat;
   logic [RW:0]          hw_up;
   logic [2*RW+1:0]      sq_up, sq_cur;
   logic                 grow_ok, shrink_need, rising;
   logic signed [PW-1:0] row_c, xs_c, xe_c, xs_clip, xe_clip;
   logic signed [QW+1:0] q_next;

   assign r_sat = (int'(req_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : req_radius;

   // half-width grows on the upper half and shrinks on the lower half
   assign rising      = (dy_ff <= 0);
   assign hw_up       = {1'b0, hw_ff} + 1'b1;
   assign sq_up       = hw_up * hw_up;
   assign sq_cur      = (2*RW+2)'(hw_ff) * (2*RW+2)'(hw_ff);
   assign grow_ok     = (sq_up <= (2*RW+2)'(q_ff));
   assign shrink_need = (sq_cur > (2*RW+2)'(q_ff));

   assign row_c   = cy_ff + PW'(dy_ff);
   assign xs_c    = cx_ff - PW'({1'b0, hw_ff});
   assign xe_c    = cx_ff + PW'({1'b0, hw_ff});
   assign xs_clip = (xs_c < 0) ? '0 : xs_c;
   assign xe_clip = (xe_c > XMAX) ? XMAX : xe_c;

   // r*r - (dy+1)^2 = q - (2*dy + 1)
   assign q_next = (QW+2)'(signed'({2'b00, q_ff})) -
                   (((QW+2)'(dy_ff) <<< 1) + (QW+2)'(1));

   assign sts.adj_need   = rising ? grow_ok : shrink_need;
   assign sts.span_vis   = (row_c >= 0) && (row_c < YLIM) && (xs_clip <= xe_clip);
   assign sts.pend_valid = pend_valid_ff;
   assign sts.dy_at_end  = (dy_ff == DW'(signed'({1'b0, r_ff})));
   assign sts.out_free   = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cx_ff    <= PW'(req_center_x);
         cy_ff    <= PW'(req_center_y);
         r_ff     <= r_sat;
         dy_ff    <= -DW'(signed'({1'b0, r_sat}));
         hw_ff    <= '0;
         q_ff     <= '0;
         paint_ff <= req_paint;
      end else begin
         if (cmd.adj_step) begin
            hw_ff <= rising ? hw_up[RW-1:0] : hw_ff - 1'b1;
         end
         if (cmd.advance) begin
            dy_ff <= dy_ff + 1'b1;
            q_ff  <= q_next[QW-1:0];
         end
      end
      if (cmd.load_pend) begin
         pend_row_ff <= row_c[CW-1:0];
         pend_xs_ff  <= xs_clip[CW-1:0];
         pend_xe_ff  <= xe_clip[CW-1:0];
      end
      if (cmd.emit_pend || cmd.emit_final) begin
         out_vis_ff   <= pend_valid_ff;
         out_last_ff  <= cmd.emit_final;
         out_row_ff   <= pend_valid_ff ? pend_row_ff : '0;
         out_xs_ff    <= pend_valid_ff ? pend_xs_ff  : '0;
         out_xe_ff    <= pend_valid_ff ? pend_xe_ff  : '0;
         out_paint_ff <= pend_valid_ff ? paint_ff    : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.start) begin
            pend_valid_ff <= 1'b0;
         end else if (cmd.load_pend) begin
            pend_valid_ff <= 1'b1;
         end
         if (cmd.emit_pend || cmd.emit_final) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_row       = out_row_ff;
   assign rsp_x_start   = out_xs_ff;
   assign rsp_x_end     = out_xe_ff;
   assign rsp_paint_out = out_paint_ff;
   assign rsp_visible   = out_vis_ff;
   assign rsp_last      = out_last_ff;

endmodule

// ===== hdl/disc_span_rasterizer.sv =====
// disc_span_rasterizer: one disc stamp in, one span word per visible row out;
//   a stamp with no visible row gives a single empty word flagged last
// a new stamp is accepted only once the previous one has issued its last word;
//   the row sequencer accepts, steps the half-width and moves on for each row, then closes
// reset: synchronous, active high; clears sequencer, pending span and output valid
module disc_span_rasterizer #(
   parameter int FRAME_WIDTH  = dsr_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = dsr_pkg::FRAME_HEIGHT_DEF,
   parameter int MAX_RADIUS   = dsr_pkg::MAX_RADIUS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // stamp request word
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [dsr_pkg::CENTER_W-1:0] req_center_x,
   input  logic signed [dsr_pkg::CENTER_W-1:0] req_center_y,
   input  logic        [dsr_pkg::RADIUS_W-1:0] req_radius,
   input  logic        [dsr_pkg::PAINT_W-1:0]  req_paint,
   // span response word
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [dsr_pkg::COORD_W-1:0]  rsp_row,
   output logic        [dsr_pkg::COORD_W-1:0]  rsp_x_start,
   output logic        [dsr_pkg::COORD_W-1:0]  rsp_x_end,
   output logic        [dsr_pkg::PAINT_W-1:0]  rsp_paint_out,
   output logic                                rsp_visible,
   output logic                                rsp_last
);

   // command and status between sequencer and datapath
   dsr_pkg::cmd_type cmd;
   dsr_pkg::sts_type sts;

   // sequencer: idle, walk rows top to bottom, then send the closing word.
   // each visible span is parked one row so the last one can be flagged
   dsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: half-width follows the circle edge one step per cycle,
   // spans are clipped to the frame and shipped through an output register
   dsr_datapath #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .MAX_RADIUS   (MAX_RADIUS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_radius    (req_radius),
      .req_paint     (req_paint),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_row       (rsp_row),
      .rsp_x_start   (rsp_x_start),
      .rsp_x_end     (rsp_x_end),
      .rsp_paint_out (rsp_paint_out),
      .rsp_visible   (rsp_visible),
      .rsp_last      (rsp_last)
   );

   // one stamp at a time: an accepted stamp blocks the next one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("stamp accepted while busy");

   // the empty-stamp word always closes its stamp
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_last)
      else $error("empty result without last");

   // the empty-stamp word carries zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |->
         rsp_row == '0 && rsp_x_start == '0 && rsp_x_end == '0 && rsp_paint_out == '0)
      else $error("empty result with nonzero fields");

   // a stalled word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_row) && $stable(rsp_x_start) && $stable(rsp_x_end) &&
         $stable(rsp_paint_out) && $stable(rsp_visible) && $stable(rsp_last))
      else $error("stalled word changed");

endmodule
